### rtl/rtks_pkg.sv
// Shared types and constants for the record table with key search.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rtks_pkg;

  // Fixed field widths of one record and of the item fields.
  localparam int unsigned HEAD_W     = 8;
  localparam int unsigned TAIL_W     = 64;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned ITEM_POS_W = 8;
  localparam int unsigned COMMAND_W  = 2;
  localparam int unsigned STATUS_W   = 3;

  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [ITEM_POS_W-1:0] item_pos_t;

  // Command codes of an input item.
  typedef enum logic [COMMAND_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } command_e;

  // Status codes of a result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_RECORD    = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_EMPTY     = 3'd6
  } status_e;

  // One stored record: three strings, each split into head and tail.
  typedef struct packed {
    logic [HEAD_W-1:0] first_head;
    logic [TAIL_W-1:0] first_tail;
    logic [HEAD_W-1:0] surname_head;
    logic [TAIL_W-1:0] surname_tail;
    logic [HEAD_W-1:0] phone_head;
    logic [TAIL_W-1:0] phone_tail;
  } record_t;

  // Table read address selection.
  typedef enum logic [2:0] {
    RD_NONE  = 3'd0,
    RD_FIRST = 3'd1,
    RD_POS   = 3'd2,
    RD_NEXT  = 3'd3,
    RD_SKIP  = 3'd4
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    rd_sel_e rd_sel;
    logic    idx_clr;
    logic    idx_load_pos;
    logic    idx_inc;
    logic    add_wr;
    logic    shift_wr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    pend_push;
    logic    out_final;
    status_e fin_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    command_e command;
    logic     full;
    logic     empty;
    logic     pos_bad;
    logic     pos_last;
    logic     shift_last;
    logic     scan_last;
    logic     hit;
    logic     pend_valid;
    logic     out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/rtks_if.sv
// Valid/ready channel interfaces for the record table: input items and results.
// Depends on rtks_pkg for the field widths.
`default_nettype none

interface rtks_in_if;
  import rtks_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COMMAND_W-1:0]  command;
  logic [ITEM_POS_W-1:0] position;
  logic [HEAD_W-1:0]     first_head;
  logic [TAIL_W-1:0]     first_tail;
  logic [HEAD_W-1:0]     surname_head;
  logic [TAIL_W-1:0]     surname_tail;
  logic [HEAD_W-1:0]     phone_head;
  logic [TAIL_W-1:0]     phone_tail;

  modport source (
    output valid, command, position, first_head, first_tail,
           surname_head, surname_tail, phone_head, phone_tail,
    input  ready
  );
  modport sink (
    input  valid, command, position, first_head, first_tail,
           surname_head, surname_tail, phone_head, phone_tail,
    output ready
  );
endinterface

interface rtks_out_if;
  import rtks_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    entry_position;
  logic [HEAD_W-1:0]   out_first_head;
  logic [TAIL_W-1:0]   out_first_tail;
  logic [HEAD_W-1:0]   out_surname_head;
  logic [TAIL_W-1:0]   out_surname_tail;
  logic [HEAD_W-1:0]   out_phone_head;
  logic [TAIL_W-1:0]   out_phone_tail;
  logic                last_result;

  modport source (
    output valid, status, entry_position, out_first_head, out_first_tail,
           out_surname_head, out_surname_tail, out_phone_head, out_phone_tail,
           last_result,
    input  ready
  );
  modport sink (
    input  valid, status, entry_position, out_first_head, out_first_tail,
           out_surname_head, out_surname_tail, out_phone_head, out_phone_tail,
           last_result,
    output ready
  );
endinterface

`default_nettype wire

### rtl/rtks_datapath.sv
// Datapath of the record table: table memory, entry count, walk index,
// pending record and output register. Depends on rtks_pkg.
`default_nettype none

module rtks_datapath #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // Input item payload.
  input  rtks_pkg::command_e        command_i,
  input  rtks_pkg::item_pos_t       position_i,
  input  rtks_pkg::record_t         item_i,
  // Controller interface.
  input  rtks_pkg::dp_cmd_t         cmd_i,
  output rtks_pkg::dp_stat_t        stat_o,
  // Result register.
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output rtks_pkg::status_e         out_status_o,
  output rtks_pkg::pos_t            out_pos_o,
  output rtks_pkg::record_t         out_rec_o,
  output logic                      out_last_o
);
  import rtks_pkg::*;

  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W  = CNT_W + 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  // Latched item.
  command_e  cmd_q;
  item_pos_t pos_q;
  record_t   item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= command_i;
      pos_q  <= position_i;
      item_q <= item_i;
    end
  end

  // Entry count and walk index.
  cnt_t count_q, count_d;
  cnt_t idx_q, idx_d;
  cmp_t idx_p1, idx_p2;

  assign idx_p1 = cmp_t'(idx_q) + cmp_t'(1);
  assign idx_p2 = cmp_t'(idx_q) + cmp_t'(2);

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + cnt_t'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - cnt_t'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_load_pos) begin
      idx_d = cnt_t'(pos_q - item_pos_t'(1));
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_p1[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Table memory: one write port, one registered read port.
  record_t table_q [TABLE_DEPTH];
  record_t rd_data_q;
  addr_t   rd_addr;
  logic    rd_en;
  addr_t   wr_addr;
  record_t wr_data;
  logic    wr_en;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_FIRST: rd_addr = '0;
      RD_POS:   rd_addr = pos_q[ADDR_W-1:0];
      RD_NEXT:  rd_addr = idx_p1[ADDR_W-1:0];
      RD_SKIP:  rd_addr = idx_p2[ADDR_W-1:0];
      default:  rd_addr = '0;
    endcase
  end

  assign rd_en   = (cmd_i.rd_sel != RD_NONE);
  assign wr_en   = cmd_i.add_wr | cmd_i.shift_wr;
  assign wr_addr = cmd_i.shift_wr ? idx_q[ADDR_W-1:0] : count_q[ADDR_W-1:0];
  assign wr_data = cmd_i.shift_wr ? rd_data_q : item_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= table_q[rd_addr];
    end
  end

  // Pending record and output register.
  record_t pend_q;
  pos_t    pend_pos_q;
  logic    pend_valid_q;
  logic    out_valid_q;
  status_e out_status_q;
  pos_t    out_pos_q;
  record_t out_rec_q;
  logic    out_last_q;
  logic    out_load;
  logic    out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (cmd_i.pend_push && pend_valid_q) || cmd_i.out_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.pend_push) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.out_final) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_push) begin
      pend_q     <= rd_data_q;
      pend_pos_q <= pos_t'(idx_p1);
    end
    if (out_load) begin
      if (pend_valid_q) begin
        out_status_q <= ST_RECORD;
        out_pos_q    <= pend_pos_q;
        out_rec_q    <= pend_q;
      end else begin
        out_status_q <= cmd_i.fin_status;
        out_pos_q    <= '0;
        out_rec_q    <= '0;
      end
      out_last_q <= cmd_i.out_final;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_pos_o    = out_pos_q;
  assign out_rec_o    = out_rec_q;
  assign out_last_o   = out_last_q;

  // Status toward the controller.
  always_comb begin
    stat_o            = '0;
    stat_o.command    = cmd_q;
    stat_o.full       = (count_q == cnt_t'(TABLE_DEPTH));
    stat_o.empty      = (count_q == '0);
    stat_o.pos_bad    = (pos_q == '0) || (pos_q > item_pos_t'(count_q));
    stat_o.pos_last   = (pos_q == item_pos_t'(count_q));
    stat_o.shift_last = (idx_p2 == cmp_t'(count_q));
    stat_o.scan_last  = (idx_p1 == cmp_t'(count_q));
    stat_o.hit        = (cmd_q == CMD_LIST) ||
                        ((rd_data_q.first_head == item_q.first_head) &&
                         (rd_data_q.first_tail == item_q.first_tail));
    stat_o.pend_valid = pend_valid_q;
    stat_o.out_free   = out_free;
  end

  // The entry count never passes the table depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A shift only moves entries that lie inside the table.
  a_shift_inside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_wr |-> (idx_p1 < cmp_t'(count_q)))
    else $error("shift write outside the occupied entries");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  // An add is never written into a full table.
  a_add_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_wr |-> (count_q < cnt_t'(TABLE_DEPTH)))
    else $error("add written into a full table");

endmodule

`default_nettype wire

### rtl/rtks_ctrl.sv
// Controller state machine of the record table: sequences decode, the
// delete shift, the search/list walk and the final result. Depends on rtks_pkg.
`default_nettype none

module rtks_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  rtks_pkg::dp_stat_t   stat_i,
  output rtks_pkg::dp_cmd_t    cmd_o
);
  import rtks_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e  state_q, state_d;
  status_e fin_q, fin_d;

  // Next state, final status and datapath commands.
  always_comb begin
    state_d          = state_q;
    fin_d            = fin_q;
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_NONE;
    cmd_o.fin_status = fin_q;
    in_ready_o       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_FINISH;
        unique case (stat_i.command)
          CMD_ADD: begin
            if (stat_i.full) begin
              fin_d = ST_FULL;
            end else begin
              cmd_o.add_wr  = 1'b1;
              cmd_o.cnt_inc = 1'b1;
              fin_d         = ST_ADDED;
            end
          end
          CMD_DELETE: begin
            if (stat_i.pos_bad) begin
              fin_d = ST_BAD_INDEX;
            end else if (stat_i.pos_last) begin
              cmd_o.cnt_dec = 1'b1;
              fin_d         = ST_DELETED;
            end else begin
              cmd_o.idx_load_pos = 1'b1;
              cmd_o.rd_sel       = RD_POS;
              fin_d              = ST_DELETED;
              state_d            = S_SHIFT;
            end
          end
          CMD_SEARCH, CMD_LIST: begin
            fin_d = (stat_i.command == CMD_SEARCH) ? ST_NOT_FOUND : ST_EMPTY;
            if (!stat_i.empty) begin
              cmd_o.idx_clr = 1'b1;
              cmd_o.rd_sel  = RD_FIRST;
              state_d       = S_SCAN;
            end
          end
          default: begin
            fin_d = ST_EMPTY;
          end
        endcase
      end

      // Each cycle moves one entry down by one place.
      S_SHIFT: begin
        cmd_o.shift_wr = 1'b1;
        if (stat_i.shift_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FINISH;
        end else begin
          cmd_o.rd_sel  = RD_SKIP;
          cmd_o.idx_inc = 1'b1;
        end
      end

      // Each cycle examines one entry unless a hit must wait for the output.
      S_SCAN: begin
        if (!(stat_i.hit && stat_i.pend_valid && !stat_i.out_free)) begin
          cmd_o.pend_push = stat_i.hit;
          if (stat_i.scan_last) begin
            state_d = S_FINISH;
          end else begin
            cmd_o.rd_sel  = RD_NEXT;
            cmd_o.idx_inc = 1'b1;
          end
        end
      end

      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_final = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered final status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= ST_ADDED;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

endmodule

`default_nettype wire

### rtl/record_table_with_key_search.sv
// Top level of the record table with key search: joins the controller and
// the datapath to the channel interfaces. Depends on rtks_pkg and rtks_if.
//
//   Channel | Direction | Carries
//   --------+-----------+-------------------------------------------------
//   in_i    | sink      | command, position, first name/surname/phone
//   out_o   | source    | status, entry position, record fields, last flag
//
// Add and bad-index or end-of-table delete pass from the decode state to the finish state.
// Delete at position p first shifts every entry above p down by one place.
// Search and list walk the table from the first entry, reading one entry a cycle.
// A result waiting in the output register stalls the walk only on a new hit;
// the next item is taken once the final result is loaded.
// After reset the table is empty; entries are only read below the count.
`default_nettype none

module record_table_with_key_search #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  rtks_in_if.sink    in_i,
  rtks_out_if.source out_o
);
  import rtks_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;
  record_t  item;
  status_e  out_status;
  pos_t     out_pos;
  record_t  out_rec;
  logic     out_valid;
  logic     out_last;

  // Gather the item payload into a record.
  always_comb begin
    item.first_head   = in_i.first_head;
    item.first_tail   = in_i.first_tail;
    item.surname_head = in_i.surname_head;
    item.surname_tail = in_i.surname_tail;
    item.phone_head   = in_i.phone_head;
    item.phone_tail   = in_i.phone_tail;
  end

  assign in_i.ready = in_ready;

  rtks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  rtks_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (command_e'(in_i.command)),
    .position_i   (in_i.position),
    .item_i       (item),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_status),
    .out_pos_o    (out_pos),
    .out_rec_o    (out_rec),
    .out_last_o   (out_last)
  );

  // Drive the result channel.
  assign out_o.valid            = out_valid;
  assign out_o.status           = out_status;
  assign out_o.entry_position   = out_pos;
  assign out_o.out_first_head   = out_rec.first_head;
  assign out_o.out_first_tail   = out_rec.first_tail;
  assign out_o.out_surname_head = out_rec.surname_head;
  assign out_o.out_surname_tail = out_rec.surname_tail;
  assign out_o.out_phone_head   = out_rec.phone_head;
  assign out_o.out_phone_tail   = out_rec.phone_tail;
  assign out_o.last_result      = out_last;

endmodule

`default_nettype wire

### test/tb_record_table_with_key_search.sv
// Self-checking testbench for record_table_with_key_search.
// Depends on rtks_pkg, the channel interfaces in rtks_if and the top-level RTL.
`timescale 1ns / 1ps

module tb_record_table_with_key_search;
  import rtks_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_ITEMS = 20;
  localparam int unsigned MAX_REPORTS = 10;

  // One input item as the source drives it.
  typedef struct packed {
    command_e  cmd;
    item_pos_t pos;
    record_t   rec;
  } table_op_t;

  // One result as the block returns it.
  typedef struct packed {
    status_e status;
    pos_t    position;
    record_t rec;
    logic    last;
  } table_result_t;

  // One row of the directed stimulus, with its hand-typed status where it has one.
  typedef struct packed {
    table_op_t op;
    logic      typed;
    status_e   typed_st;
  } stim_row_t;

  // First name only, used for the name pool.
  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [TAIL_W-1:0] tail;
  } name_t;

  localparam record_t REC_ZERO = '0;
  localparam record_t REC_ONES = '1;
  // "ALICE" with a zero-padded tail.
  localparam record_t REC_ALICE_A = {8'h41, 64'h4C49434500000000, 8'h53,
                                     64'h4D49544800000000, 8'h35, 64'h3535313233340000};
  localparam record_t REC_ALICE_B = {8'h41, 64'h4C49434500000000, 8'h4A,
                                     64'h4F4E455300000000, 8'h30, 64'h3132333435363738};
  // Same visible name, but a byte after the padding zero differs.
  localparam record_t REC_ALICE_X = {8'h41, 64'h4C49434500000058, 8'h42,
                                     64'h524F574E00000000, 8'h39, 64'h3837363534333231};
  localparam record_t REC_ZED = {8'h5A, 64'h4544000000000000, 8'h00,
                                 64'h0, 8'h00, 64'h0};

  logic clk_i;
  logic rst_ni;

  rtks_in_if  in_if ();
  rtks_out_if out_if ();

  record_table_with_key_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the table and the results still owed by the block.
  record_t       shadow_rows [TABLE_DEPTH];
  int unsigned   shadow_count;
  table_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  name_t         name_pool [4];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        calm_stretch;
  logic        cur_typed;
  status_e     cur_typed_st;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Queue one result; a negative index gives a plain status result.
  function automatic void push_result(status_e st, int idx);
    table_result_t r;
    r = '0;
    r.status = st;
    if (idx >= 0) begin
      r.position = pos_t'(idx + 1);
      r.rec = shadow_rows[idx];
    end
    pending_results.push_back(r);
  endfunction

  // Apply one operation to the shadow table and queue the results it causes.
  function automatic void predict_table_op(command_e cmd, item_pos_t pos, record_t rec);
    int unsigned hits;
    hits = 0;
    case (cmd)
      CMD_ADD: begin
        if (shadow_count >= TABLE_DEPTH) begin
          push_result(ST_FULL, -1);
        end else begin
          shadow_rows[shadow_count] = rec;
          shadow_count++;
          push_result(ST_ADDED, -1);
        end
      end
      CMD_DELETE: begin
        if (pos == 0 || pos > shadow_count) begin
          push_result(ST_BAD_INDEX, -1);
        end else begin
          for (int i = pos - 1; i + 1 < shadow_count; i++) begin
            shadow_rows[i] = shadow_rows[i + 1];
          end
          shadow_count--;
          shadow_rows[shadow_count] = '0;
          push_result(ST_DELETED, -1);
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_rows[i].first_head == rec.first_head &&
              shadow_rows[i].first_tail == rec.first_tail) begin
            push_result(ST_RECORD, i);
            hits++;
          end
        end
        if (hits == 0) begin
          push_result(ST_NOT_FOUND, -1);
        end
      end
      default: begin
        for (int i = 0; i < shadow_count; i++) begin
          push_result(ST_RECORD, i);
        end
        if (shadow_count == 0) begin
          push_result(ST_EMPTY, -1);
        end
      end
    endcase
    pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [TAIL_W-1:0] rand_tail();
    return {$urandom(), $urandom()};
  endfunction

  function automatic record_t rand_record();
    return {8'($urandom()), rand_tail(), 8'($urandom()), rand_tail(),
            8'($urandom()), rand_tail()};
  endfunction

  function automatic int unsigned draw_gap();
    return calm_stretch ? 0 : $urandom_range(0, 11);
  endfunction

  // Random operation, biased toward ones that hit live entries.
  function automatic table_op_t rand_table_op();
    table_op_t   op;
    int unsigned pick;
    int unsigned sel;
    int unsigned row_idx;
    name_t       key;
    op.rec = rand_record();
    op.pos = 8'($urandom());
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    if (pick < 40) begin
      op.cmd = CMD_ADD;
      if (sel < 60) begin
        key = name_pool[$urandom_range(0, 3)];
        op.rec.first_head = key.head;
        op.rec.first_tail = key.tail;
      end
    end else if (pick < 60) begin
      op.cmd = CMD_DELETE;
      if (sel < 75 && shadow_count > 0) begin
        op.pos = item_pos_t'($urandom_range(1, shadow_count));
      end else if (sel < 90) begin
        op.pos = item_pos_t'(shadow_count + 1);
      end
    end else if (pick < 85) begin
      op.cmd = CMD_SEARCH;
      if (sel < 65 && shadow_count > 0) begin
        row_idx = $urandom_range(0, shadow_count - 1);
        key.head = shadow_rows[row_idx].first_head;
        key.tail = shadow_rows[row_idx].first_tail;
        op.rec.first_head = key.head;
        op.rec.first_tail = key.tail;
        // Near miss: one bit of the key flipped.
        if ($urandom_range(0, 3) == 0) begin
          op.rec.first_tail = key.tail ^ (64'h1 << $urandom_range(0, 63));
        end
      end else if (sel < 85) begin
        key = name_pool[$urandom_range(0, 3)];
        op.rec.first_head = key.head;
        op.rec.first_tail = key.tail;
      end
    end else begin
      op.cmd = CMD_LIST;
    end
    return op;
  endfunction

  function automatic void stim_row(command_e cmd, item_pos_t pos, record_t rec,
                                   logic typed, status_e typed_st);
    stim_row_t row;
    row.op.cmd = cmd;
    row.op.pos = pos;
    row.op.rec = rec;
    row.typed = typed;
    row.typed_st = typed_st;
    directed_rows.push_back(row);
  endfunction

  // Present one item after a random gap and hold it until the transfer.
  task automatic send_item(table_op_t op, logic typed, status_e typed_st);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= op.cmd;
    in_if.position     <= op.pos;
    in_if.first_head   <= op.rec.first_head;
    in_if.first_tail   <= op.rec.first_tail;
    in_if.surname_head <= op.rec.surname_head;
    in_if.surname_tail <= op.rec.surname_tail;
    in_if.phone_head   <= op.rec.phone_head;
    in_if.phone_tail   <= op.rec.phone_tail;
    cur_typed          <= typed;
    cur_typed_st       <= typed_st;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    @(negedge clk_i);
  endtask

  task automatic send_op(command_e cmd, item_pos_t pos, record_t rec);
    table_op_t op;
    op.cmd = cmd;
    op.pos = pos;
    op.rec = rec;
    send_item(op, 1'b0, ST_ADDED);
  endtask

  // Predict on each input transfer, then check each output transfer.
  always @(posedge clk_i) begin : check_proc
    table_result_t got;
    table_result_t exp;
    int unsigned   size_mark;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        size_mark = pending_results.size();
        predict_table_op(command_e'(in_if.command), in_if.position,
                         {in_if.first_head, in_if.first_tail, in_if.surname_head,
                          in_if.surname_tail, in_if.phone_head, in_if.phone_tail});
        // Rows with a hand-typed status replace the predicted single result.
        if (cur_typed) begin
          while (pending_results.size() > size_mark) void'(pending_results.pop_back());
          exp = '0;
          exp.status = cur_typed_st;
          exp.last = 1'b1;
          pending_results.push_back(exp);
        end
      end
      if (out_if.valid && out_if.ready) begin
        got.status = status_e'(out_if.status);
        got.position = out_if.entry_position;
        got.rec = {out_if.out_first_head, out_if.out_first_tail, out_if.out_surname_head,
                   out_if.out_surname_tail, out_if.out_phone_head, out_if.out_phone_tail};
        got.last = out_if.last_result;
        if (pending_results.size() == 0) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("unexpected result: status=%0d pos=%0d rec=%h last=%b",
                     got.status, got.position, got.rec, got.last);
          end
          mismatch_count++;
        end else begin
          exp = pending_results.pop_front();
          if (got.status !== exp.status || got.position !== exp.position ||
              got.rec.first_head !== exp.rec.first_head ||
              got.rec.first_tail !== exp.rec.first_tail ||
              got.rec.surname_head !== exp.rec.surname_head ||
              got.rec.surname_tail !== exp.rec.surname_tail ||
              got.rec.phone_head !== exp.rec.phone_head ||
              got.rec.phone_tail !== exp.rec.phone_tail ||
              got.last !== exp.last) begin
            if (mismatch_count < MAX_REPORTS) begin
              $display("mismatch: expected status=%0d pos=%0d rec=%h last=%b",
                       exp.status, exp.position, exp.rec, exp.last);
              $display("          got      status=%0d pos=%0d rec=%h last=%b",
                       got.status, got.position, got.rec, got.last);
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  // Result side: a random stall before each result transfer.
  initial begin : result_sink
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      @(negedge clk_i);
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("record_table_with_key_search verification failed");
    $finish;
  end

  // Reset, directed rows, random operations, a fill to capacity, then drain.
  initial begin : stimulus
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.command      = CMD_ADD;
    in_if.position     = '0;
    in_if.first_head   = '0;
    in_if.first_tail   = '0;
    in_if.surname_head = '0;
    in_if.surname_tail = '0;
    in_if.phone_head   = '0;
    in_if.phone_tail   = '0;
    cur_typed          = 1'b0;
    cur_typed_st       = ST_ADDED;
    calm_stretch       = 1'b0;
    shadow_count       = 0;
    mismatch_count     = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) shadow_rows[i] = '0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty table, extremes, duplicate and near-duplicate names.
    stim_row(CMD_LIST,   8'd0,   REC_ZERO,    1'b1, ST_EMPTY);
    stim_row(CMD_SEARCH, 8'd0,   REC_ZERO,    1'b1, ST_NOT_FOUND);
    stim_row(CMD_DELETE, 8'd0,   REC_ZERO,    1'b1, ST_BAD_INDEX);
    stim_row(CMD_DELETE, 8'd1,   REC_ONES,    1'b1, ST_BAD_INDEX);
    stim_row(CMD_ADD,    8'd0,   REC_ZERO,    1'b1, ST_ADDED);
    stim_row(CMD_ADD,    8'd255, REC_ONES,    1'b1, ST_ADDED);
    stim_row(CMD_ADD,    8'd0,   REC_ALICE_A, 1'b1, ST_ADDED);
    stim_row(CMD_ADD,    8'd0,   REC_ALICE_B, 1'b1, ST_ADDED);
    stim_row(CMD_ADD,    8'd0,   REC_ALICE_X, 1'b1, ST_ADDED);
    stim_row(CMD_SEARCH, 8'd0,   REC_ALICE_A, 1'b0, ST_ADDED);
    stim_row(CMD_SEARCH, 8'd0,   REC_ALICE_X, 1'b0, ST_ADDED);
    stim_row(CMD_SEARCH, 8'd0,   REC_ZERO,    1'b0, ST_ADDED);
    stim_row(CMD_SEARCH, 8'd0,   REC_ONES,    1'b0, ST_ADDED);
    stim_row(CMD_LIST,   8'd0,   REC_ZERO,    1'b0, ST_ADDED);
    stim_row(CMD_DELETE, 8'd6,   REC_ZERO,    1'b1, ST_BAD_INDEX);
    stim_row(CMD_DELETE, 8'd255, REC_ZERO,    1'b1, ST_BAD_INDEX);
    stim_row(CMD_DELETE, 8'd5,   REC_ZERO,    1'b1, ST_DELETED);
    stim_row(CMD_DELETE, 8'd1,   REC_ZERO,    1'b1, ST_DELETED);
    stim_row(CMD_LIST,   8'd0,   REC_ZERO,    1'b0, ST_ADDED);
    stim_row(CMD_SEARCH, 8'd0,   REC_ZED,     1'b1, ST_NOT_FOUND);
    stim_row(CMD_DELETE, 8'd2,   REC_ZERO,    1'b1, ST_DELETED);
    stim_row(CMD_LIST,   8'd0,   REC_ZERO,    1'b0, ST_ADDED);
    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].op, directed_rows[k].typed, directed_rows[k].typed_st);
    end

    // Small pool of first names so that searches find several entries.
    for (int i = 0; i < 4; i++) begin
      name_pool[i].head = 8'($urandom());
      name_pool[i].tail = rand_tail();
    end
    name_pool[3].tail = {$urandom(), 8'h00, 24'($urandom())};

    // Random part, with stretches where neither side idles.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 16 == 0) calm_stretch = ($urandom_range(0, 2) == 0);
      send_item(rand_table_op(), 1'b0, ST_ADDED);
    end
    calm_stretch = 1'b0;

    // Fill to capacity, overflow it, then walk and shrink the full table.
    while (shadow_count < TABLE_DEPTH) begin
      send_op(CMD_ADD, 8'd0, rand_record());
    end
    send_op(CMD_ADD, 8'd0, rand_record());
    send_op(CMD_ADD, 8'd0, REC_ONES);
    send_op(CMD_LIST, 8'd0, REC_ZERO);
    send_op(CMD_SEARCH, 8'd0, {name_pool[0], 144'h0});
    send_op(CMD_DELETE, 8'(TABLE_DEPTH + 1), REC_ZERO);
    send_op(CMD_DELETE, 8'(TABLE_DEPTH), REC_ZERO);
    send_op(CMD_DELETE, 8'd1, REC_ZERO);
    send_op(CMD_SEARCH, 8'd0, {name_pool[3], 144'h0});
    send_op(CMD_ADD, 8'd0, rand_record());
    send_op(CMD_LIST, 8'd0, REC_ZERO);
    in_if.valid <= 1'b0;

    // Drain: every owed result, then a quiet stretch for stray ones.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("record_table_with_key_search verification clean");
    end else begin
      $display("record_table_with_key_search verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rtks_pkg.sv
rtl/rtks_if.sv
rtl/rtks_datapath.sv
rtl/rtks_ctrl.sv
rtl/record_table_with_key_search.sv
test/tb_record_table_with_key_search.sv
